// File: sv/pwcd_pkg.sv
// ----------------------------------------------------------------------------
// pwcd_pkg
// Shared types, constants and the command classifier for the pulse-width
// command decoder.
// ----------------------------------------------------------------------------
package pwcd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CAP_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;
  localparam int BYTE_WIDTH  = 8;
  localparam int CLASS_WIDTH = 3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX           = '1;
  localparam logic [CAP_WIDTH-1:0]   TIMEOUT_CAP_RESET = CAP_WIDTH'(200);
  localparam logic [BYTE_WIDTH-1:0]  FIRST_BITS_MAX    = BYTE_WIDTH'(8);
  localparam logic [BYTE_WIDTH-1:0]  BIT_COUNT_MAX     = '1;

  localparam logic [BYTE_WIDTH-1:0] CODE_ID          = 8'h00;
  localparam logic [BYTE_WIDTH-1:0] CODE_STATUS      = 8'h40;
  localparam logic [BYTE_WIDTH-1:0] CODE_ORIGIN      = 8'h41;
  localparam logic [BYTE_WIDTH-1:0] CODE_RECALIBRATE = 8'h42;
  localparam logic [BYTE_WIDTH-1:0] CODE_STATUS_LONG = 8'h43;
  localparam logic [BYTE_WIDTH-1:0] CODE_MOTOR_RESET = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLS_ID          = 3'd0,
    CLS_STATUS      = 3'd1,
    CLS_ORIGIN      = 3'd2,
    CLS_RECALIBRATE = 3'd3,
    CLS_STATUS_LONG = 3'd4,
    CLS_MOTOR_RESET = 3'd5,
    CLS_OTHER       = 3'd6
  } cmd_class_t;

  typedef struct packed {
    logic                   event_res;
    logic [BYTE_WIDTH-1:0]  command_byte;
    cmd_class_t             command_class;
    logic [BYTE_WIDTH-1:0]  bits_received;
  } result_t;

  function automatic cmd_class_t classify(input logic [BYTE_WIDTH-1:0] b);
    cmd_class_t c;
    unique case (b)
      CODE_ID:          c = CLS_ID;
      CODE_STATUS:      c = CLS_STATUS;
      CODE_ORIGIN:      c = CLS_ORIGIN;
      CODE_RECALIBRATE: c = CLS_RECALIBRATE;
      CODE_STATUS_LONG: c = CLS_STATUS_LONG;
      CODE_MOTOR_RESET: c = CLS_MOTOR_RESET;
      default:          c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

// File: sv/pwcd_core.sv
// ----------------------------------------------------------------------------
// pwcd_core
// Pulse-width bit decoder: phase tracking, high/low counters, kept bit period,
// first-byte capture and end-of-command detection for one sample per step.
// ----------------------------------------------------------------------------
module pwcd_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pwcd_pkg::CAP_WIDTH-1:0]       cfg_data,
  input  logic                                 step,
  input  logic                                 pin_level,
  input  logic                                 reset_n,
  output logic                                 res_valid,
  output pwcd_pkg::result_t                    res
);

  localparam int CW = pwcd_pkg::COUNT_WIDTH;
  localparam int BW = pwcd_pkg::BYTE_WIDTH;

  pwcd_pkg::phase_t                  phase, phase_next;
  logic [CW-1:0]                     high_count, high_count_next;
  logic [CW-1:0]                     low_count, low_count_next;
  logic [CW:0]                       last_bit_period, last_bit_period_next;
  logic [BW-1:0]                     first_bits, first_bits_next;
  logic [BW-1:0]                     bit_count, bit_count_next;
  logic [pwcd_pkg::CAP_WIDTH-1:0]    timeout_cap;

  logic [CW-1:0]      high_inc;
  logic [CW-1:0]      low_inc;
  logic [CW:0]        period;
  logic               bit_val;
  logic               cmd_end;
  logic [3:0]         shift_n;
  logic [2*BW-1:0]    aligned;
  logic [BW-1:0]      byte_val;

  always_comb begin
    high_inc = (high_count == pwcd_pkg::CNT_MAX) ? high_count : high_count + CW'(1);
    low_inc  = (low_count == pwcd_pkg::CNT_MAX) ? low_count : low_count + CW'(1);
    period   = {1'b0, high_count} + {1'b0, low_inc};
    bit_val  = !(high_count > low_inc);
    cmd_end  = ((last_bit_period != '0) && ({1'b0, low_inc} > last_bit_period)) ||
               (pwcd_pkg::CMP_WIDTH'(low_inc) > pwcd_pkg::CMP_WIDTH'(timeout_cap)) ||
               (low_inc == pwcd_pkg::CNT_MAX);
    shift_n  = (bit_count < pwcd_pkg::FIRST_BITS_MAX) ? 4'd8 - bit_count[3:0] : 4'd0;
    aligned  = {{BW{1'b0}}, first_bits} << shift_n;
    byte_val = aligned[BW-1:0];
  end

  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        pwcd_pkg::PH_IDLE: begin
          if (pin_level) phase_next = pwcd_pkg::PH_HIGH;
        end
        pwcd_pkg::PH_HIGH: begin
          if (!pin_level) phase_next = pwcd_pkg::PH_LOW;
        end
        default: begin
          if (pin_level) begin
            phase_next = pwcd_pkg::PH_HIGH;
          end else if (cmd_end) begin
            phase_next = pwcd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    high_count_next      = high_count;
    low_count_next       = low_count;
    last_bit_period_next = last_bit_period;
    first_bits_next      = first_bits;
    bit_count_next       = bit_count;
    res_valid            = 1'b0;
    res                  = '0;
    if (step) begin
      unique case (phase)
        pwcd_pkg::PH_IDLE: begin
          if (pin_level) begin
            high_count_next = CW'(1);
            low_count_next  = '0;
            first_bits_next = '0;
            bit_count_next  = '0;
          end else if (!reset_n) begin
            res_valid     = 1'b1;
            res.event_res = 1'b1;
          end
        end
        pwcd_pkg::PH_HIGH: begin
          high_count_next = high_inc;
          if (!pin_level) low_count_next = CW'(1);
        end
        default: begin
          low_count_next = low_inc;
          if (pin_level) begin
            last_bit_period_next = period;
            if (bit_count < pwcd_pkg::FIRST_BITS_MAX) first_bits_next = {first_bits[BW-2:0], bit_val};
            if (bit_count != pwcd_pkg::BIT_COUNT_MAX) bit_count_next = bit_count + BW'(1);
            high_count_next = CW'(1);
            low_count_next  = '0;
          end else if (cmd_end) begin
            res_valid         = 1'b1;
            res.command_byte  = byte_val;
            res.command_class = pwcd_pkg::classify(byte_val);
            res.bits_received = bit_count;
            high_count_next   = '0;
            low_count_next    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= pwcd_pkg::PH_IDLE;
      high_count      <= '0;
      low_count       <= '0;
      last_bit_period <= '0;
      first_bits      <= '0;
      bit_count       <= '0;
      timeout_cap     <= pwcd_pkg::TIMEOUT_CAP_RESET;
    end else begin
      phase           <= phase_next;
      high_count      <= high_count_next;
      low_count       <= low_count_next;
      last_bit_period <= last_bit_period_next;
      first_bits      <= first_bits_next;
      bit_count       <= bit_count_next;
      if (cfg_we) timeout_cap <= cfg_data;
    end
  end

endmodule

// File: sv/pwcd_out.sv
// ----------------------------------------------------------------------------
// pwcd_out
// Result register: holds one decoded word until the master side takes it.
// ----------------------------------------------------------------------------
module pwcd_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pwcd_pkg::result_t  load_data,
  input  logic               out_ready,
  output logic               out_valid,
  output pwcd_pkg::result_t  out_data
);

  logic out_valid_next;

  always_comb begin
    priority if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= load_data;
  end

endmodule

// File: sv/pulse_width_command_decoder_top.sv
// ----------------------------------------------------------------------------
// pulse_width_command_decoder_top
// Path: a sample that causes a result word is captured in the input register,
// then decoded into the result register, from which the word is offered.
// Throughput: one pin sample per cycle while the result register drains.
// Reset: rst (synchronous) returns to idle, clears the kept bit period and
// sets timeout_cap to 200.
// ----------------------------------------------------------------------------
module pulse_width_command_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pwcd_pkg::CAP_WIDTH-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // pin_level, reset_n, zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // command_byte, command_class,
                                                           // bits_received, zero pad
  output logic                              m_axis_tuser   // event_res
);

  logic               in_valid;
  logic               in_pin;
  logic               in_rst_n;
  logic               step;
  logic               res_valid;
  pwcd_pkg::result_t  res;
  pwcd_pkg::result_t  out_data;

  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pin   <= s_axis_tdata[0];
      in_rst_n <= s_axis_tdata[1];
    end
  end

  pwcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .step      (step),
    .pin_level (in_pin),
    .reset_n   (in_rst_n),
    .res_valid (res_valid),
    .res       (res)
  );

  pwcd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_data (res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data)
  );

  assign m_axis_tuser = out_data.event_res;
  assign m_axis_tdata = {5'd0, out_data.bits_received, out_data.command_class,
                         out_data.command_byte};

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the pulse-width command decoder against its own decode model.
// Pin samples go in as single words on the sample stream. Each accepted word
// is run through the model, which queues the report it should produce. Every
// report word that leaves the block is compared field by field with the
// oldest queued report. Directed tests cover reset requests, a zero timeout
// cap, every command class, short, long and overlong commands and the bit
// count limit. Random traffic follows under several timeout caps, with
// bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int TOTAL_SAMPLES = 1350;
  localparam int SAT_BITS = 258;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [pwcd_pkg::CAP_WIDTH-1:0] cfg_data;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;   // pin_level, reset_n, zero pad
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [23:0]                    m_axis_tdata;   // command_byte, command_class,
                                                  // bits_received, zero pad
  logic                           m_axis_tuser;   // event_res

  pulse_width_command_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // decode model state
  pwcd_pkg::phase_t                 ph         = pwcd_pkg::PH_IDLE;
  logic [pwcd_pkg::COUNT_WIDTH-1:0] hi_cnt     = '0;
  logic [pwcd_pkg::COUNT_WIDTH-1:0] lo_cnt     = '0;
  logic [pwcd_pkg::COUNT_WIDTH:0]   period     = '0;
  logic [7:0]                       first_bits = '0;
  logic [7:0]                       bit_cnt    = '0;
  logic [pwcd_pkg::CAP_WIDTH-1:0]   cap        = pwcd_pkg::TIMEOUT_CAP_RESET;

  pwcd_pkg::result_t due_reports[$];
  int unsigned errors = 0;
  int unsigned samples_sent = 0;
  int unsigned commands_seen = 0;
  int unsigned resets_seen = 0;
  int unsigned caps_written = 0;
  logic [6:0]  classes_seen = '0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned quiet = 0;
  int unsigned stall_cyc = 0;
  int unsigned stall_mode = 0;

  function automatic pwcd_pkg::cmd_class_t command_kind(input logic [7:0] b);
    case (b)
      pwcd_pkg::CODE_ID:          return pwcd_pkg::CLS_ID;
      pwcd_pkg::CODE_STATUS:      return pwcd_pkg::CLS_STATUS;
      pwcd_pkg::CODE_ORIGIN:      return pwcd_pkg::CLS_ORIGIN;
      pwcd_pkg::CODE_RECALIBRATE: return pwcd_pkg::CLS_RECALIBRATE;
      pwcd_pkg::CODE_STATUS_LONG: return pwcd_pkg::CLS_STATUS_LONG;
      pwcd_pkg::CODE_MOTOR_RESET: return pwcd_pkg::CLS_MOTOR_RESET;
      default:                    return pwcd_pkg::CLS_OTHER;
    endcase
  endfunction

  task automatic decode_sample(input logic pin, input logic rstn);
    pwcd_pkg::result_t r;
    logic              bitv;
    int unsigned       n;
    logic [7:0]        b;
    case (ph)
      pwcd_pkg::PH_IDLE: begin
        if (pin) begin
          ph = pwcd_pkg::PH_HIGH;
          hi_cnt = pwcd_pkg::COUNT_WIDTH'(1);
          lo_cnt = '0;
          first_bits = '0;
          bit_cnt = '0;
        end else if (!rstn) begin
          r.event_res = 1'b1;
          r.command_byte = '0;
          r.command_class = pwcd_pkg::CLS_ID;
          r.bits_received = '0;
          due_reports.push_back(r);
        end
      end
      pwcd_pkg::PH_HIGH: begin
        if (hi_cnt != pwcd_pkg::CNT_MAX) hi_cnt++;
        if (!pin) begin
          ph = pwcd_pkg::PH_LOW;
          lo_cnt = pwcd_pkg::COUNT_WIDTH'(1);
        end
      end
      default: begin
        if (lo_cnt != pwcd_pkg::CNT_MAX) lo_cnt++;
        if (pin) begin
          bitv = !(hi_cnt > lo_cnt);
          period = {1'b0, hi_cnt} + {1'b0, lo_cnt};
          if (bit_cnt < 8) first_bits = {first_bits[6:0], bitv};
          if (bit_cnt != pwcd_pkg::BIT_COUNT_MAX) bit_cnt++;
          ph = pwcd_pkg::PH_HIGH;
          hi_cnt = pwcd_pkg::COUNT_WIDTH'(1);
          lo_cnt = '0;
        end else if ((period != 0 && {1'b0, lo_cnt} > period) || lo_cnt > cap ||
                     lo_cnt == pwcd_pkg::CNT_MAX) begin
          n = (bit_cnt < 8) ? bit_cnt : 8;
          b = first_bits << (8 - n);
          r.event_res = 1'b0;
          r.command_byte = b;
          r.command_class = command_kind(b);
          r.bits_received = bit_cnt;
          due_reports.push_back(r);
          ph = pwcd_pkg::PH_IDLE;
          hi_cnt = '0;
          lo_cnt = '0;
        end
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_sample(input logic pin, input logic rstn);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, rstn, pin};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
    decode_sample(pin, rstn);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (due_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout_cap(input logic [pwcd_pkg::CAP_WIDTH-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap = v;
    caps_written++;
  endtask

  task automatic finish_command();
    while (ph != pwcd_pkg::PH_IDLE) send_sample(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_bit(input logic bitv, input int unsigned u);
    int unsigned hi_len;
    int unsigned lo_len;
    hi_len = bitv ? u : 3 * u;
    lo_len = bitv ? 3 * u : u;
    repeat (hi_len) send_sample(1'b1, 1'($urandom_range(0, 1)));
    repeat (lo_len) send_sample(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_command(input logic [7:0] lead, input int unsigned nbits,
                              input int unsigned u);
    for (int unsigned i = 0; i < nbits; i++)
      send_bit((i < 8) ? lead[7 - i] : 1'($urandom_range(0, 1)), u);
    finish_command();
  endtask

  task automatic test_reset_request();
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    // zero-bit command ended by the default cap
    send_sample(1'b1, 1'b0);
    finish_command();
    send_sample(1'b0, 1'b0);
  endtask

  task automatic test_zero_cap();
    write_timeout_cap('0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);
  endtask

  task automatic test_command_classes();
    logic [7:0] codes[7];
    codes = '{pwcd_pkg::CODE_ID, pwcd_pkg::CODE_STATUS, pwcd_pkg::CODE_ORIGIN,
              pwcd_pkg::CODE_RECALIBRATE, pwcd_pkg::CODE_STATUS_LONG,
              pwcd_pkg::CODE_MOTOR_RESET, 8'hA5};
    write_timeout_cap(pwcd_pkg::TIMEOUT_CAP_RESET);
    foreach (codes[i]) send_command(codes[i], 8, 1);
    send_command(8'hE0, 3, 2);
  endtask

  task automatic test_long_commands();
    send_command(pwcd_pkg::CODE_STATUS, 12, 1);
    send_command(pwcd_pkg::CODE_ORIGIN, 16, 1);
  endtask

  // shortest bits: one high and one low sample each
  task automatic test_bit_count_limit();
    send_sample(1'b1, 1'b1);
    repeat (SAT_BITS) begin
      send_sample(1'b0, 1'($urandom_range(0, 1)));
      send_sample(1'b1, 1'($urandom_range(0, 1)));
    end
    finish_command();
  endtask

  task automatic test_random_traffic();
    logic [7:0]  codes[6];
    logic [7:0]  lead;
    int unsigned p;
    int unsigned r;
    int unsigned phase_start;
    int unsigned nbits;
    codes = '{pwcd_pkg::CODE_ID, pwcd_pkg::CODE_STATUS, pwcd_pkg::CODE_ORIGIN,
              pwcd_pkg::CODE_RECALIBRATE, pwcd_pkg::CODE_STATUS_LONG,
              pwcd_pkg::CODE_MOTOR_RESET};
    p = 0;
    while (samples_sent < TOTAL_SAMPLES) begin
      finish_command();
      case (p % 4)
        0: write_timeout_cap(pwcd_pkg::TIMEOUT_CAP_RESET);
        1: write_timeout_cap(16'd1);
        2: write_timeout_cap(16'hFFFF);
        default: write_timeout_cap(pwcd_pkg::CAP_WIDTH'($urandom_range(2, 400)));
      endcase
      phase_start = samples_sent;
      while (samples_sent - phase_start < 80 && samples_sent < TOTAL_SAMPLES) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          lead = ($urandom_range(0, 9) < 3) ? codes[$urandom_range(0, 5)]
                                            : 8'($urandom_range(0, 255));
          nbits = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 16);
          send_command(lead, nbits, $urandom_range(1, 2));
        end else if (r < 80) begin
          repeat ($urandom_range(1, 3)) send_sample(1'b0, 1'b0);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 20))
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 10)) send_sample(1'b1, 1'($urandom_range(0, 1)));
          repeat ($urandom_range(1, 30)) send_sample(1'b0, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      p++;
    end
    gaps_on = 1'b1;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_cyc % 8 < 5);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    pwcd_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report word, expected none, actual %h/%b", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = due_reports.pop_front();
        if (want.event_res) resets_seen++;
        else begin
          commands_seen++;
          classes_seen[want.command_class] = 1'b1;
        end
        if (m_axis_tuser !== want.event_res)
          report_mismatch("event_res", want.event_res, m_axis_tuser);
        if (m_axis_tdata[7:0] !== want.command_byte)
          report_mismatch("command_byte", want.command_byte, m_axis_tdata[7:0]);
        if (m_axis_tdata[10:8] !== want.command_class)
          report_mismatch("command_class", want.command_class, m_axis_tdata[10:8]);
        if (m_axis_tdata[18:11] !== want.bits_received)
          report_mismatch("bits_received", want.bits_received, m_axis_tdata[18:11]);
        if (m_axis_tdata[23:19] !== 5'd0)
          report_mismatch("tdata pad", 0, m_axis_tdata[23:19]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, quiet);
      $display("[pulse_width_command_decoder_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_request();
    test_zero_cap();
    test_command_classes();
    test_long_commands();
    test_bit_count_limit();
    test_random_traffic();

    wait_drained();
    repeat (8) @(negedge clk);
    if (due_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, due_reports.size());
      errors++;
    end

    $display("Sent %0d pin samples under %0d timeout cap writes.", samples_sent, caps_written);
    $display("Checked %0d command reports (classes seen %b) and %0d reset reports.",
             commands_seen, classes_seen, resets_seen);
    if (errors == 0) begin
      $display("[pulse_width_command_decoder_top] OK");
    end else begin
      $display("[pulse_width_command_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

// File: pulse_width_command_decoder_top.f
sv/pwcd_pkg.sv
sv/pwcd_core.sv
sv/pwcd_out.sv
sv/pulse_width_command_decoder_top.sv
tb/tb.sv
